// ===== rtl/snsg_pkg.sv =====
`default_nettype none
package snsg_pkg;

    // Q20 fixed point
    localparam int GAIN_W     = 21;
    localparam int GAIN_SHIFT = 20;
    localparam int POW_SHIFT  = 28;
    localparam logic [GAIN_W-1:0] Q20_ONE  = 21'd1048576;
    localparam logic [GAIN_W-1:0] Q20_HALF = 21'd524288;

    // Field widths
    localparam int BIN_W    = 8;
    localparam int SAMPLE_W = 32;
    localparam int NOISE_W  = 32;
    localparam int POWER_W  = 31;
    localparam int ADK_W    = 24;

    // Register reset values and default depth
    localparam logic [GAIN_W-1:0] TRIGGER_RESET = 21'd1048576;
    localparam logic [GAIN_W-1:0] ALPHA_RESET   = 21'd996147;
    localparam int NUM_BINS_DEF = 256;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESENCE_TRIGGER = 2'd0,
        REG_SMOOTHING_ALPHA  = 2'd1
    } cfg_reg_t;

    // Divider: quotient is below 2^19 whenever it is used
    localparam int QUO_W = 19;
    localparam int REM_W = POWER_W + GAIN_SHIFT;
    localparam int DVS_W = 32;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       half;
    } div_side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        div_side_t        side;
    } div_item_t;

endpackage
`default_nettype wire

// ===== rtl/snsg_ram.sv =====
`default_nettype none
module snsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/snsg_div.sv =====
`default_nettype none
module snsg_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire snsg_pkg::div_item_t   in_item,
    output logic                       out_valid,
    output logic [snsg_pkg::QUO_W-1:0] out_quo,
    output snsg_pkg::div_side_t        out_side
);
    import snsg_pkg::*;

    logic             v_reg    [QUO_W];
    logic [REM_W-1:0] rem_reg  [QUO_W];
    logic [DVS_W-1:0] dvs_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    div_side_t        side_reg [QUO_W];

    // restoring division, one quotient bit per stage, MSB first
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int Bit = QUO_W - 1 - k;
        logic             v_prev;
        logic [REM_W-1:0] rem_prev;
        logic [DVS_W-1:0] dvs_prev;
        logic [QUO_W-1:0] quo_prev;
        div_side_t        side_prev;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = in_item.rem;
            assign dvs_prev  = in_item.dvs;
            assign quo_prev  = '0;
            assign side_prev = in_item.side;
        end else begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign dvs_prev  = dvs_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            trial    = REM_W'(dvs_prev) << Bit;
            rem_next = rem_prev;
            quo_next = quo_prev;
            if (rem_prev >= trial) begin
                rem_next      = rem_prev - trial;
                quo_next[Bit] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                dvs_reg[k]  <= dvs_prev;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/spectral_noise_suppress_gain.sv =====
`default_nettype none
// Per-bin noise suppression gain. Each item is one complex spectrum bin; the
// block updates that bin's recursive noise estimate and returns the bin scaled
// by a Q20 gain between 0.5 and 1.0. One item is taken per clock cycle unless
// the output stalls, in any bin order, including the same bin in consecutive
// cycles (the noise update loop is one register stage wide, with forwarding
// around the store). Results pass the front stages, the 19-stage quotient
// pipeline and the output registers. After reset the noise store is cleared
// one entry per cycle, and no item is taken until it is clear; configuration
// writes are taken at any time and should be made while no item is in flight.
module spectral_noise_suppress_gain #(
    parameter int NUM_BINS = snsg_pkg::NUM_BINS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [snsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [snsg_pkg::GAIN_W-1:0]     cfg_data,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // bin_index[7:0], mic_re[39:8], mic_im[71:40], presence_gain[92:72], zero pad
    input  wire logic [95:0]                     s_tdata,
    // gain_present[0]
    input  wire logic                            s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_re[31:0], out_im[63:32], applied_gain[84:64], zero pad
    output logic [87:0]                          m_tdata
);
    import snsg_pkg::*;

    localparam int IDX_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int IDX_TAB = 1 << BIN_W;

    logic adv;

    // ---------------- configuration ----------------
    logic [GAIN_W-1:0] trigger_reg;
    logic [GAIN_W-1:0] alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_reg <= TRIGGER_RESET;
            alpha_reg   <= ALPHA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PRESENCE_TRIGGER: trigger_reg <= cfg_data;
                REG_SMOOTHING_ALPHA:  alpha_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- clearing pass ----------------
    logic             clear_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clear_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(NUM_BINS - 1)) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // ---------------- input skid ----------------
    logic                 skid_v_reg;
    logic [95:0]          skid_data_reg;
    logic                 skid_user_reg;
    logic                 s_acc;
    logic                 pin_valid;
    logic [95:0]          pin_data;
    logic                 pin_user;

    assign s_tready = !skid_v_reg && !clear_reg;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
        end else if (adv) begin
            skid_v_reg <= 1'b0;
        end else if (s_acc) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_acc) begin
            skid_data_reg <= s_tdata;
            skid_user_reg <= s_tuser;
        end
    end

    assign pin_valid = skid_v_reg || s_acc;
    assign pin_data  = skid_v_reg ? skid_data_reg : s_tdata;
    assign pin_user  = skid_v_reg ? skid_user_reg : s_tuser;

    // bin index folded into the store depth
    logic [IDX_W-1:0] idx_tab [IDX_TAB];
    for (genvar i = 0; i < IDX_TAB; i++) begin : g_idx
        assign idx_tab[i] = IDX_W'(i % NUM_BINS);
    end

    // ---------------- stage 1: presence select ----------------
    logic                       v1_reg;
    logic [IDX_W-1:0]           idx1_reg;
    logic signed [SAMPLE_W-1:0] re1_reg, im1_reg;
    logic [GAIN_W-1:0]          spp1_reg;
    logic [GAIN_W-1:0]          spp_next;
    logic [GAIN_W-1:0]          pin_pg;

    assign pin_pg = pin_data[92:72];

    always_comb begin
        if (!pin_user) begin
            spp_next = '0;
        end else if (pin_pg > trigger_reg) begin
            spp_next = Q20_ONE;
        end else begin
            spp_next = pin_pg;
        end
    end

    // ---------------- stage 2: squares, alpha*spp ----------------
    logic                       v2_reg;
    logic [IDX_W-1:0]           idx2_reg;
    logic signed [SAMPLE_W-1:0] re2_reg, im2_reg;
    logic [GAIN_W-1:0]          spp2_reg;
    logic signed [63:0]         rr2_reg, ii2_reg;
    logic [2*GAIN_W-1:0]        asp2_reg;

    // ---------------- stage 3: power, adk ----------------
    logic                       v3_reg;
    logic [IDX_W-1:0]           idx3_reg;
    logic signed [SAMPLE_W-1:0] re3_reg, im3_reg;
    logic [POWER_W-1:0]         power3_reg;
    logic signed [ADK_W-1:0]    adk3_reg;
    logic [63:0]                sq_sum;
    logic [35:0]                sq_sh;
    logic [POWER_W-1:0]         power_next;
    logic signed [ADK_W-1:0]    adk_next;

    assign sq_sum = 64'(rr2_reg[62:0]) + 64'(ii2_reg[62:0]);
    assign sq_sh  = sq_sum[63:POW_SHIFT];

    always_comb begin
        if (sq_sh[35:POWER_W] != '0) begin
            power_next = '1;
        end else begin
            power_next = sq_sh[POWER_W-1:0];
        end
        adk_next = $signed({3'b000, alpha_reg}) + $signed({3'b000, spp2_reg})
                 - $signed({2'b00, asp2_reg[2*GAIN_W-1:GAIN_SHIFT]});
    end

    // ---------------- stage 4: power*(1-adk), store read ----------------
    logic                       v4_reg;
    logic [IDX_W-1:0]           idx4_reg;
    logic signed [SAMPLE_W-1:0] re4_reg, im4_reg;
    logic [POWER_W-1:0]         power4_reg;
    logic signed [ADK_W-1:0]    adk4_reg;
    logic signed [55:0]         pterm4_reg;
    logic signed [ADK_W-1:0]    omadk3;

    assign omadk3 = $signed({3'b000, Q20_ONE}) - adk3_reg;

    // ---------------- stage 5: noise update ----------------
    logic                       v5_reg;
    logic [IDX_W-1:0]           idx5_reg;
    logic signed [SAMPLE_W-1:0] re5_reg, im5_reg;
    logic [POWER_W-1:0]         power5_reg;
    logic [NOISE_W-1:0]         noise5_reg;
    logic [NOISE_W-1:0]         ram_rd;
    logic [NOISE_W-1:0]         noise_old;
    logic signed [56:0]         nprod;
    logic signed [57:0]         nsum;
    logic [NOISE_W-1:0]         noise_next;

    // last value written, for the read that overlapped the write
    logic                       lw_v_reg;
    logic [IDX_W-1:0]           lw_idx_reg;
    logic [NOISE_W-1:0]         lw_data_reg;

    always_comb begin
        priority if (v5_reg && idx5_reg == idx4_reg) begin
            noise_old = noise5_reg;
        end else if (lw_v_reg && lw_idx_reg == idx4_reg) begin
            noise_old = lw_data_reg;
        end else begin
            noise_old = ram_rd;
        end
    end

    assign nprod = $signed({1'b0, noise_old}) * adk4_reg;
    assign nsum  = 58'(nprod >>> GAIN_SHIFT) + 58'(pterm4_reg >>> GAIN_SHIFT);

    always_comb begin
        if (nsum < 0) begin
            noise_next = '0;
        end else if (nsum > 58'sd2147483647) begin
            noise_next = 32'h7FFF_FFFF;
        end else begin
            noise_next = nsum[NOISE_W-1:0];
        end
    end

    // store write: clearing pass or the leaving update
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [NOISE_W-1:0] wr_data;

    assign wr_en   = clear_reg || (adv && v5_reg);
    assign wr_addr = clear_reg ? clr_cnt_reg : idx5_reg;
    assign wr_data = clear_reg ? '0 : noise5_reg;

    snsg_ram #(
        .WIDTH (NOISE_W),
        .DEPTH (NUM_BINS)
    ) u_noise_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (idx3_reg),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_v_reg <= 1'b0;
        end else if (!clear_reg && adv && v5_reg) begin
            lw_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clear_reg && adv && v5_reg) begin
            lw_idx_reg  <= idx5_reg;
            lw_data_reg <= noise5_reg;
        end
    end

    // ---------------- stage 6: divider set-up ----------------
    logic      v6_reg;
    div_item_t div6_reg;
    div_item_t div_next;

    always_comb begin
        div_next.rem       = {noise5_reg[POWER_W-1:0], {GAIN_SHIFT{1'b0}}};
        div_next.dvs       = DVS_W'(power5_reg) + 1'b1;
        div_next.side.re   = re5_reg;
        div_next.side.im   = im5_reg;
        div_next.side.half = ({noise5_reg, 1'b0} >= 33'(power5_reg));
    end

    // ---------------- front pipeline registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= pin_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx1_reg   <= idx_tab[pin_data[BIN_W-1:0]];
            re1_reg    <= pin_data[39:8];
            im1_reg    <= pin_data[71:40];
            spp1_reg   <= spp_next;

            idx2_reg   <= idx1_reg;
            re2_reg    <= re1_reg;
            im2_reg    <= im1_reg;
            spp2_reg   <= spp1_reg;
            rr2_reg    <= re1_reg * re1_reg;
            ii2_reg    <= im1_reg * im1_reg;
            asp2_reg   <= alpha_reg * spp1_reg;

            idx3_reg   <= idx2_reg;
            re3_reg    <= re2_reg;
            im3_reg    <= im2_reg;
            power3_reg <= power_next;
            adk3_reg   <= adk_next;

            idx4_reg   <= idx3_reg;
            re4_reg    <= re3_reg;
            im4_reg    <= im3_reg;
            power4_reg <= power3_reg;
            adk4_reg   <= adk3_reg;
            pterm4_reg <= $signed({1'b0, power3_reg}) * omadk3;

            idx5_reg   <= idx4_reg;
            re5_reg    <= re4_reg;
            im5_reg    <= im4_reg;
            power5_reg <= power4_reg;
            noise5_reg <= noise_next;

            div6_reg   <= div_next;
        end
    end

    // ---------------- quotient pipeline ----------------
    logic             dq_valid;
    logic [QUO_W-1:0] dq_quo;
    div_side_t        dq_side;

    snsg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v6_reg),
        .in_item   (div6_reg),
        .out_valid (dq_valid),
        .out_quo   (dq_quo),
        .out_side  (dq_side)
    );

    // ---------------- gain, scale, output ----------------
    logic                       vg_reg;
    logic signed [SAMPLE_W-1:0] reg_re_reg, reg_im_reg;
    logic [GAIN_W-1:0]          gain_g_reg;
    logic [GAIN_W-1:0]          gain_next;

    logic                       vm_reg;
    logic signed [53:0]         prod_re_reg, prod_im_reg;
    logic [GAIN_W-1:0]          gain_m_reg;

    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        out_re_reg, out_im_reg;
    logic [GAIN_W-1:0]          out_gain_reg;

    assign gain_next = dq_side.half ? Q20_HALF : (Q20_ONE - GAIN_W'(dq_quo));
    assign adv       = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg       <= 1'b0;
            vm_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vg_reg       <= dq_valid;
            vm_reg       <= vg_reg;
            m_tvalid_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            reg_re_reg   <= dq_side.re;
            reg_im_reg   <= dq_side.im;
            gain_g_reg   <= gain_next;

            prod_re_reg  <= reg_re_reg * $signed({1'b0, gain_g_reg});
            prod_im_reg  <= reg_im_reg * $signed({1'b0, gain_g_reg});
            gain_m_reg   <= gain_g_reg;

            out_re_reg   <= prod_re_reg[51:20];
            out_im_reg   <= prod_im_reg[51:20];
            out_gain_reg <= gain_m_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_gain_reg, out_im_reg, out_re_reg};

`ifndef SYNTHESIS
    // nothing enters while the store is being cleared
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> !s_tready)
        else $error("item taken during clearing pass");

    // the pipeline is empty whenever the clearing pass writes
    a_clear_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> (!v5_reg && !v1_reg))
        else $error("update in flight during clearing pass");

    // a parked item leaves the skid on the next advance
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && skid_v_reg) |=> !skid_v_reg)
        else $error("skid item not drained");

    // applied gain stays between one half and one
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_gain_reg >= Q20_HALF && out_gain_reg <= Q20_ONE))
        else $error("applied gain out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import snsg_pkg::*;

    localparam int LATENCY   = 29;
    localparam int NBINS     = 256;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [7:0]         bin;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [20:0]        pg;
        logic               present;
    } bin_item_t;

    // packed from the top down, so re sits in the lowest bits
    typedef struct packed {
        logic [20:0]        gain;
        logic signed [31:0] im;
        logic signed [31:0] re;
    } scaled_bin_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [87:0] m_tdata;

    spectral_noise_suppress_gain i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [20:0] trig_q = TRIGGER_RESET;
    logic [20:0] alpha_q = ALPHA_RESET;
    longint noise_est [NBINS];

    bin_item_t   pending_bins[$];
    scaled_bin_t expected_bins[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    bit cfg_busy = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // floor shift for signed values
    function automatic longint fsr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic scaled_bin_t suppress_bin(input bin_item_t it);
        longint spp, alpha, adk, re, im, pwr, nz, g;
        logic [63:0] sq;
        scaled_bin_t r;
        re = it.re;
        im = it.im;
        if (!it.present) spp = 0;
        else if (it.pg > trig_q) spp = 1048576;
        else spp = it.pg;
        alpha = alpha_q;
        adk = alpha + spp - fsr(alpha * spp, 20);
        sq = 64'(re * re) + 64'(im * im);
        sq = sq >> 28;
        pwr = (sq > 64'd2147483647) ? 2147483647 : longint'(sq);
        nz = fsr(noise_est[it.bin] * adk, 20) + fsr(pwr * (1048576 - adk), 20);
        if (nz < 0) nz = 0;
        if (nz > 2147483647) nz = 2147483647;
        noise_est[it.bin] = nz;
        if (nz * 2 >= pwr) g = 524288;
        else g = 1048576 - (1048576 * nz) / (pwr + 1);
        if (g > 1048576) g = 1048576;
        r.re = 32'(fsr(re * g, 20));
        r.im = 32'(fsr(im * g, 20));
        r.gain = 21'(g);
        return r;
    endfunction

    // driver: one item per handshake from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_bins.push_back(suppress_bin(pending_bins.pop_front()));
            if (pending_bins.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                bin_item_t nx;
                nx = pending_bins[0];
                s_tvalid <= 1'b1;
                s_tdata <= {3'b0, nx.pg, nx.im, nx.re, nx.bin};
                s_tuser <= nx.present;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        m_tready <= aresetn && !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            scaled_bin_t got, want;
            got = m_tdata[84:0];
            if (expected_bins.size() == 0) begin
                report("unexpected item", 0, 0);
            end else begin
                want = expected_bins.pop_front();
                if (got.re !== want.re) report("out_re", got.re, want.re);
                if (got.im !== want.im) report("out_im", got.im, want.im);
                if (got.gain !== want.gain) report("applied_gain", got.gain, want.gain);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [20:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_PRESENCE_TRIGGER) trig_q = val;
        else alpha_q = val;
    endtask

    task automatic drain();
        while (pending_bins.size() != 0 || s_tvalid || expected_bins.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(65535)) - 32768);
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< $urandom_range(14);
        endcase
    endfunction

    task automatic queue_bin(input logic [7:0] b, input logic [31:0] re, input logic [31:0] im,
                             input logic [20:0] pg, input logic pr);
        bin_item_t it;
        it.bin = b; it.re = re; it.im = im; it.pg = pg; it.present = pr;
        pending_bins.push_back(it);
    endtask

    task automatic queue_random(input int n);
        repeat (n) begin
            logic [20:0] pg;
            pg = $urandom_range(3) == 0 ? 21'($urandom) : 21'($urandom_range(1048576));
            // a few bins keep recurring so the noise estimates build up
            queue_bin($urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom),
                      rand_sample(), rand_sample(), pg, 1'($urandom));
        end
    endtask

    initial begin
        int ph;
        foreach (noise_est[i]) noise_est[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, missing gain, repeated bin, zero power
        queue_bin(8'd0, 32'd0, 32'd0, 21'd0, 1'b0);
        queue_bin(8'd255, 32'h7fff_ffff, 32'h7fff_ffff, 21'h1f_ffff, 1'b1);
        queue_bin(8'd255, 32'h8000_0000, 32'h8000_0000, 21'd1048576, 1'b1);
        queue_bin(8'd255, 32'h8000_0000, 32'h7fff_ffff, 21'd0, 1'b1);
        queue_bin(8'd1, 32'hffff_ffff, 32'd1, 21'h1f_ffff, 1'b0);
        queue_bin(8'd1, 32'h4000_0000, 32'hc000_0000, 21'd524288, 1'b1);
        queue_bin(8'd1, 32'h0001_0000, 32'h0000_0000, 21'd1048577, 1'b1);
        queue_bin(8'd2, 32'h1234_5678, 32'hedcb_a988, 21'd1, 1'b1);
        queue_bin(8'd2, 32'h0000_4000, 32'h0000_4000, 21'd0, 1'b0);
        queue_bin(8'd2, 32'h0000_4000, 32'h0000_4000, 21'd0, 1'b0);
        queue_bin(8'd128, 32'h5555_5555, 32'haaaa_aaaa, 21'h15_5555, 1'b1);
        queue_bin(8'd127, 32'haaaa_aaaa, 32'h5555_5555, 21'h0a_aaaa, 1'b1);
        drain();

        // random phases across register settings and idling patterns
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(REG_PRESENCE_TRIGGER, 21'd0);
                         write_reg(REG_SMOOTHING_ALPHA, 21'd0); end
                1: begin write_reg(REG_PRESENCE_TRIGGER, 21'h1f_ffff);
                         write_reg(REG_SMOOTHING_ALPHA, 21'h1f_ffff); end
                2: begin write_reg(REG_PRESENCE_TRIGGER, 21'd1048576);
                         write_reg(REG_SMOOTHING_ALPHA, 21'd1048576); end
                3: begin write_reg(REG_PRESENCE_TRIGGER, 21'd524288);
                         write_reg(REG_SMOOTHING_ALPHA, 21'd996147); end
                default: begin write_reg(REG_PRESENCE_TRIGGER, 21'($urandom));
                         write_reg(REG_SMOOTHING_ALPHA, 21'($urandom_range(1048576))); end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            queue_random(140);
            if (ph == 2) begin
                // long receiver hold-off while items keep coming
                hold_recv = 1'b1;
                repeat (200) @(posedge aclk);
                hold_recv = 1'b0;
            end
            drain();
        end

        if (errors == 0 && expected_bins.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
